// File: hdl/wccs_pkg.sv
// Shared types, constants and helpers of the wake cue capture sequencer.
package wccs_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int N_COUNTERS  = 14;
    localparam int N_STAMPS    = 9;
    localparam int CNT_IDX_W   = $clog2(N_COUNTERS);
    localparam int STAMP_IDX_W = $clog2(N_STAMPS);
    localparam int S_DATA_W    = 136;
    localparam int M_DATA_W    = 40;

    typedef logic [CNT_IDX_W-1:0]   cnt_idx_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam cnt_idx_t CNT_DETECT      = cnt_idx_t'(0);
    localparam cnt_idx_t CNT_REJECT      = cnt_idx_t'(1);
    localparam cnt_idx_t CNT_RGB         = cnt_idx_t'(2);
    localparam cnt_idx_t CNT_ATTEMPT     = cnt_idx_t'(3);
    localparam cnt_idx_t CNT_CUE_FAIL    = cnt_idx_t'(4);
    localparam cnt_idx_t CNT_CUE_START   = cnt_idx_t'(5);
    localparam cnt_idx_t CNT_CUE_DONE    = cnt_idx_t'(6);
    localparam cnt_idx_t CNT_CUE_TIMEOUT = cnt_idx_t'(7);
    localparam cnt_idx_t CNT_HANDOFF     = cnt_idx_t'(8);
    localparam cnt_idx_t CNT_CAP_START   = cnt_idx_t'(9);
    localparam cnt_idx_t CNT_CAP_OK      = cnt_idx_t'(10);
    localparam cnt_idx_t CNT_CAP_FAIL    = cnt_idx_t'(11);
    localparam cnt_idx_t CNT_ABORT       = cnt_idx_t'(12);
    localparam cnt_idx_t CNT_ORDER       = cnt_idx_t'(13);

    localparam int ST_DETECT    = 0;
    localparam int ST_RGB       = 1;
    localparam int ST_PAUSED    = 2;
    localparam int ST_CUE_START = 3;
    localparam int ST_CUE_END   = 4;
    localparam int ST_CAP_START = 5;
    localparam int ST_CAP_END   = 6;
    localparam int ST_PREROLL   = 7;
    localparam int ST_DURATION  = 8;

    typedef enum logic [3:0] {
        KIND_DETECT     = 4'd0,
        KIND_RGB        = 4'd1,
        KIND_PAUSED     = 4'd2,
        KIND_CUE_START  = 4'd3,
        KIND_CUE_UPDATE = 4'd4,
        KIND_HANDOFF    = 4'd5,
        KIND_CAP_START  = 4'd6,
        KIND_CAP_FINISH = 4'd7,
        KIND_ABORT      = 4'd8
    } kind_t;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_RGB       = 8'b0000_0010,
        PH_PAUSE     = 8'b0000_0100,
        PH_CUE_WAIT  = 8'b0000_1000,
        PH_PLAYING   = 8'b0001_0000,
        PH_FAILED    = 8'b0010_0000,
        PH_READY     = 8'b0100_0000,
        PH_CAPTURING = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] now_ms;
        logic [31:0] cue_duration_ms;
        logic [31:0] cue_timeout_ms;
        logic        cue_accepted;
        logic        speaker_active;
        logic [31:0] preroll_samples;
        logic        capture_ok;
        logic [4:0]  stat_select;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic [2:0]  phase_code;
        logic        done;
        logic        timed;
        logic        bump_en;
        cnt_idx_t    bump_idx;
        logic        stat_mem;
        cnt_idx_t    stat_idx;
        logic [31:0] stat_pre;
    } evt_res_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_IDLE:      code = 3'd0;
            PH_RGB:       code = 3'd1;
            PH_PAUSE:     code = 3'd2;
            PH_CUE_WAIT:  code = 3'd3;
            PH_PLAYING:   code = 3'd4;
            PH_FAILED:    code = 3'd5;
            PH_READY:     code = 3'd6;
            PH_CAPTURING: code = 3'd7;
            default:      code = 3'd0;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/wccs_cnt_mem.sv
// Event counter memory with registered reads, write forwarding and reset valid bits.
module wccs_cnt_mem (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  wccs_pkg::cnt_idx_t  rd_addr_a,
    input  wccs_pkg::cnt_idx_t  rd_addr_b,
    input  logic                wr_en,
    input  wccs_pkg::cnt_idx_t  wr_addr,
    input  wccs_pkg::count_t    wr_data,
    output wccs_pkg::count_t    rd_data_a,
    output wccs_pkg::count_t    rd_data_b
);
    import wccs_pkg::*;

    count_t                 mem [N_COUNTERS];
    logic [N_COUNTERS-1:0]  valid_reg;
    count_t                 rd_a_reg;
    count_t                 rd_b_reg;
    logic                   va_reg;
    logic                   vb_reg;
    logic                   hit_a_reg;
    logic                   hit_b_reg;
    count_t                 fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // A write on the same edge as the read is not yet in the array, so it is forwarded.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg  <= mem[rd_addr_a];
            rd_b_reg  <= mem[rd_addr_b];
            va_reg    <= valid_reg[rd_addr_a];
            vb_reg    <= valid_reg[rd_addr_b];
            hit_a_reg <= wr_en && (wr_addr == rd_addr_a);
            hit_b_reg <= wr_en && (wr_addr == rd_addr_b);
            fwd_reg   <= wr_data;
        end
    end

    assign rd_data_a = hit_a_reg ? fwd_reg : (va_reg ? rd_a_reg : '0);
    assign rd_data_b = hit_b_reg ? fwd_reg : (vb_reg ? rd_b_reg : '0);

endmodule

// File: hdl/wccs_ctrl.sv
// Phase sequencer with deadline, timestamps and the two paired counters.
module wccs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  wccs_pkg::item_t     item,
    output wccs_pkg::evt_res_t  res
);
    import wccs_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] deadline_reg, deadline_next;
    logic        seen_reg, seen_next;
    logic [31:0] stamps_reg [N_STAMPS];
    logic [31:0] stamps_next [N_STAMPS];
    count_t      attempt_reg, attempt_next;
    count_t      timeout_reg, timeout_next;

    logic        seen_now;
    logic [31:0] diff_dl;
    logic [31:0] diff_ce;
    logic [4:0]  sel_off;
    logic        ok;
    logic        done;
    logic        timed;
    logic        bump_en;
    cnt_idx_t    bump_idx;
    logic        stat_mem;
    cnt_idx_t    stat_idx;
    logic [31:0] stat_pre;

    always_comb begin
        phase_next    = phase_reg;
        deadline_next = deadline_reg;
        seen_next     = seen_reg;
        stamps_next   = stamps_reg;
        attempt_next  = attempt_reg;
        timeout_next  = timeout_reg;
        ok            = 1'b0;
        done          = 1'b0;
        timed         = 1'b0;
        bump_en       = 1'b0;
        bump_idx      = CNT_ORDER;
        seen_now      = seen_reg | item.speaker_active;
        diff_dl       = item.now_ms - deadline_reg;
        diff_ce       = item.now_ms - stamps_reg[ST_CUE_END];

        case (item.kind)
            KIND_DETECT: begin
                bump_en = 1'b1;
                if (phase_reg != PH_IDLE) begin
                    bump_idx = CNT_REJECT;
                end else begin
                    bump_idx = CNT_DETECT;
                    for (int i = 0; i < N_STAMPS; i++) begin
                        stamps_next[i] = '0;
                    end
                    stamps_next[ST_DETECT] = item.now_ms;
                    phase_next    = PH_RGB;
                    deadline_next = '0;
                    seen_next     = 1'b0;
                    ok            = 1'b1;
                end
            end
            KIND_RGB: begin
                bump_en = 1'b1;
                if (phase_reg == PH_RGB) begin
                    bump_idx = CNT_RGB;
                    stamps_next[ST_RGB] = item.now_ms;
                    phase_next = PH_PAUSE;
                    ok         = 1'b1;
                end
            end
            KIND_PAUSED: begin
                if (phase_reg == PH_PAUSE) begin
                    stamps_next[ST_PAUSED] = item.now_ms;
                    phase_next = PH_CUE_WAIT;
                    ok         = 1'b1;
                end else begin
                    bump_en = 1'b1;
                end
            end
            KIND_CUE_START: begin
                bump_en = 1'b1;
                if (phase_reg == PH_CUE_WAIT) begin
                    attempt_next = attempt_reg + count_t'(1);
                    stamps_next[ST_DURATION]  = item.cue_duration_ms;
                    stamps_next[ST_CUE_START] = item.now_ms;
                    seen_next = 1'b0;
                    ok        = 1'b1;
                    if (!item.cue_accepted) begin
                        bump_idx = CNT_CUE_FAIL;
                        stamps_next[ST_CUE_END] = item.now_ms;
                        phase_next = PH_FAILED;
                    end else begin
                        bump_idx      = CNT_CUE_START;
                        deadline_next = item.now_ms + item.cue_duration_ms
                                        + item.cue_timeout_ms;
                        phase_next    = PH_PLAYING;
                    end
                end
            end
            KIND_CUE_UPDATE: begin
                if (phase_reg == PH_PLAYING) begin
                    seen_next = seen_now;
                    if (seen_now && !item.speaker_active) begin
                        done = 1'b1;
                    end else if (!diff_dl[31]) begin
                        done  = 1'b1;
                        timed = 1'b1;
                    end
                    if (done) begin
                        bump_en  = 1'b1;
                        bump_idx = CNT_CUE_DONE;
                        stamps_next[ST_CUE_END] = item.now_ms;
                        if (timed) begin
                            timeout_next = timeout_reg + count_t'(1);
                        end
                        phase_next = PH_READY;
                        ok         = 1'b1;
                    end
                end
            end
            KIND_HANDOFF: begin
                bump_en = 1'b1;
                if (phase_reg == PH_READY) begin
                    bump_idx = CNT_HANDOFF;
                    ok       = 1'b1;
                end
            end
            KIND_CAP_START: begin
                bump_en = 1'b1;
                if (phase_reg == PH_READY && stamps_reg[ST_CUE_END] != '0 && !diff_ce[31]) begin
                    bump_idx = CNT_CAP_START;
                    stamps_next[ST_CAP_START] = item.now_ms;
                    stamps_next[ST_PREROLL]   = item.preroll_samples;
                    phase_next = PH_CAPTURING;
                    ok         = 1'b1;
                end
            end
            KIND_CAP_FINISH: begin
                bump_en = 1'b1;
                if (phase_reg == PH_CAPTURING) begin
                    bump_idx = item.capture_ok ? CNT_CAP_OK : CNT_CAP_FAIL;
                    stamps_next[ST_CAP_END] = item.now_ms;
                    phase_next = PH_IDLE;
                    ok         = 1'b1;
                end
            end
            KIND_ABORT: begin
                bump_en  = 1'b1;
                bump_idx = CNT_ABORT;
                stamps_next[ST_CAP_END] = item.now_ms;
                phase_next    = PH_IDLE;
                deadline_next = '0;
                seen_next     = 1'b0;
                ok            = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sel_off  = item.stat_select - 5'(N_COUNTERS);
        stat_mem = 1'b0;
        stat_idx = '0;
        stat_pre = '0;
        if (item.stat_select < 5'(N_COUNTERS)) begin
            if (cnt_idx_t'(item.stat_select) == CNT_ATTEMPT) begin
                stat_pre = 32'(attempt_next);
            end else if (cnt_idx_t'(item.stat_select) == CNT_CUE_TIMEOUT) begin
                stat_pre = 32'(timeout_next);
            end else begin
                stat_mem = 1'b1;
                stat_idx = cnt_idx_t'(item.stat_select);
            end
        end else if (item.stat_select < 5'(N_COUNTERS + N_STAMPS)) begin
            stat_pre = stamps_next[sel_off[STAMP_IDX_W-1:0]];
        end
    end

    always_comb begin
        res.ok         = ok;
        res.phase_code = phase_code(phase_next);
        res.done       = done;
        res.timed      = timed;
        res.bump_en    = bump_en;
        res.bump_idx   = bump_idx;
        res.stat_mem   = stat_mem;
        res.stat_idx   = stat_idx;
        res.stat_pre   = stat_pre;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            deadline_reg <= '0;
            seen_reg     <= 1'b0;
            attempt_reg  <= '0;
            timeout_reg  <= '0;
            for (int i = 0; i < N_STAMPS; i++) begin
                stamps_reg[i] <= '0;
            end
        end else if (accept) begin
            phase_reg    <= phase_next;
            deadline_reg <= deadline_next;
            seen_reg     <= seen_next;
            attempt_reg  <= attempt_next;
            timeout_reg  <= timeout_next;
            stamps_reg   <= stamps_next;
        end
    end

endmodule

// File: hdl/wake_cue_capture_sequencer.sv
// Top level of the wake cue capture sequencer: stream ports, counter update stage, output register.
// A result is registered in the update stage, then in the output register, before the master side.
// Throughput: one beat per cycle while the output is not stalled; the counter memory is read
// on acceptance, written back as the update stage advances, same-entry overlap forwarded.
// Reset: synchronous, active low; phase returns to idle and all counters, stamps and the
// deadline read as zero right after reset, with no clearing pass.
module wake_cue_capture_sequencer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_ms, cue_duration_ms, cue_timeout_ms, cue_accepted, speaker_active,
    // preroll_samples, capture_ok, stat_select
    input  logic [wccs_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // kind
    input  logic [3:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // ok, phase_now, cue_done, cue_timed_out, stat_value, zero fill
    output logic [wccs_pkg::M_DATA_W-1:0]    m_axis_tdata
);
    import wccs_pkg::*;

    item_t       item;
    evt_res_t    res;
    evt_res_t    s1_reg;
    logic        s1_valid_reg;
    logic        m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic        accept;
    logic        adv;
    logic        wr_en;
    count_t      rd_a;
    count_t      rd_b;
    count_t      inc;
    logic [31:0] stat_val;

    always_comb begin
        item.kind            = kind_t'(s_axis_tuser);
        item.now_ms          = s_axis_tdata[31:0];
        item.cue_duration_ms = s_axis_tdata[63:32];
        item.cue_timeout_ms  = s_axis_tdata[95:64];
        item.cue_accepted    = s_axis_tdata[96];
        item.speaker_active  = s_axis_tdata[97];
        item.preroll_samples = s_axis_tdata[129:98];
        item.capture_ok      = s_axis_tdata[130];
        item.stat_select     = s_axis_tdata[135:131];
    end

    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign wr_en         = s1_valid_reg && adv && s1_reg.bump_en;
    assign inc           = rd_a + count_t'(1);

    wccs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (item),
        .res     (res)
    );

    wccs_cnt_mem u_cnt_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr_a (res.bump_idx),
        .rd_addr_b (res.stat_idx),
        .wr_en     (wr_en),
        .wr_addr   (s1_reg.bump_idx),
        .wr_data   (inc),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    always_comb begin
        if (!s1_reg.stat_mem) begin
            stat_val = s1_reg.stat_pre;
        end else if (s1_reg.bump_en && s1_reg.bump_idx == s1_reg.stat_idx) begin
            stat_val = 32'(inc);
        end else begin
            stat_val = 32'(rd_b);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_valid_reg && adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && adv) begin
            m_data_reg <= {2'b00, stat_val, s1_reg.timed, s1_reg.done,
                           s1_reg.phase_code, s1_reg.ok};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
